// ----- design/kmrd_pkg.sv -----
// ----------------------------------------------------------------------------
// kmrd_pkg
// Shared widths, defaults and reset values for the key matrix row debouncer.
// ----------------------------------------------------------------------------
package kmrd_pkg;

   localparam int ROWS_DEFAULT = 16;
   localparam int COLS_DEFAULT = 8;

   localparam int ROW_FIELD_W = 4;
   localparam int COL_FIELD_W = 8;
   localparam int CNT_W       = 8;
   localparam int ROW_EXT_W   = 7;

   localparam logic [CNT_W-1:0] LOCKOUT_RESET = 8'd3;

endpackage

// ----- design/key_matrix_row_debouncer_core.sv -----
// ----------------------------------------------------------------------------
// key_matrix_row_debouncer_core
// Debounces scanned key matrix rows with a per-key lockout after each change.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_row_index, req_raw_columns
//   rsp      out        rsp_valid/stall    rsp_out_row, rsp_debounced_bits,
//                                          rsp_toggled_bits
//   csr      in         csr_valid/ready    csr_data (lockout scans)
//
// One row per cycle sustained while rsp_stall is low; a taken row passes through
// the input stage (with the registered store read), then the result register.
// Reset clears control and the per-row valid bits at once; no clearing pass.
// A stalled result holds; one more row waits in the input stage, then
// req_stall rises. Rows at or above ROWS leave state alone and return zeros.
// ----------------------------------------------------------------------------
module key_matrix_row_debouncer_core #(
   parameter int ROWS = kmrd_pkg::ROWS_DEFAULT,
   parameter int COLS = kmrd_pkg::COLS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [kmrd_pkg::ROW_FIELD_W-1:0]    req_row_index,
   input  logic [kmrd_pkg::COL_FIELD_W-1:0]    req_raw_columns,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [kmrd_pkg::ROW_FIELD_W-1:0]    rsp_out_row,
   output logic [kmrd_pkg::COL_FIELD_W-1:0]    rsp_debounced_bits,
   output logic [kmrd_pkg::COL_FIELD_W-1:0]    rsp_toggled_bits,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kmrd_pkg::CNT_W-1:0]          csr_data
);

   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW    = COLS * kmrd_pkg::CNT_W;
   localparam int RXW   = kmrd_pkg::ROW_EXT_W;

   logic [kmrd_pkg::CNT_W-1:0]       lockout_ff;

   logic                             a_valid_ff;
   logic                             a_in_range_ff;
   logic [kmrd_pkg::ROW_FIELD_W-1:0] a_row_ff;
   logic [COLS-1:0]                  a_raw_ff;

   logic                             rsp_valid_ff;
   logic [kmrd_pkg::ROW_FIELD_W-1:0] rsp_row_ff;
   logic [kmrd_pkg::COL_FIELD_W-1:0] rsp_bits_ff;
   logic [kmrd_pkg::COL_FIELD_W-1:0] rsp_tog_ff;

   logic                             accept;
   logic                             advance;
   logic                             req_in_range;
   logic [RXW-1:0]                   req_row_ext;
   logic [RXW-1:0]                   a_row_ext;
   logic [ROW_W-1:0]                 rd_addr;
   logic [ROW_W-1:0]                 wr_addr;
   logic                             wr_en;
   logic [COLS-1:0]                  old_bits;
   logic [CW-1:0]                    old_cnt;
   logic [COLS-1:0]                  new_bits;
   logic [COLS-1:0]                  change;
   logic [CW-1:0]                    new_cnt;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff <= kmrd_pkg::LOCKOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         lockout_ff <= csr_data;
      end
   end

   assign advance   = a_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = a_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign req_row_ext  = RXW'(req_row_index);
   assign a_row_ext    = RXW'(a_row_ff);
   assign req_in_range = (req_row_ext < RXW'(ROWS));
   assign rd_addr      = req_row_ext[ROW_W-1:0];
   assign wr_addr      = a_row_ext[ROW_W-1:0];
   assign wr_en        = advance && a_in_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (accept) begin
         a_valid_ff <= 1'b1;
      end else if (advance) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_row_ff      <= req_row_index;
         a_raw_ff      <= req_raw_columns[COLS-1:0];
         a_in_range_ff <= req_in_range;
      end
   end

   kmrd_row_store #(
      .ROWS  (ROWS),
      .COLS  (COLS),
      .ROW_W (ROW_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && req_in_range),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_bits (new_bits),
      .wr_cnt  (new_cnt),
      .rd_bits (old_bits),
      .rd_cnt  (old_cnt)
   );

   kmrd_row_update #(
      .COLS (COLS)
   ) u_update (
      .raw_bits (a_raw_ff),
      .old_bits (old_bits),
      .old_cnt  (old_cnt),
      .lockout  (lockout_ff),
      .new_bits (new_bits),
      .change   (change),
      .new_cnt  (new_cnt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_row_ff <= a_row_ff;
         if (a_in_range_ff) begin
            rsp_bits_ff <= kmrd_pkg::COL_FIELD_W'(new_bits);
            rsp_tog_ff  <= kmrd_pkg::COL_FIELD_W'(change);
         end else begin
            rsp_bits_ff <= '0;
            rsp_tog_ff  <= '0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_row        = rsp_row_ff;
   assign rsp_debounced_bits = rsp_bits_ff;
   assign rsp_toggled_bits   = rsp_tog_ff;

`ifndef SYNTHESIS
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a held result");

   a_out_of_range_quiet: assert property (@(posedge clock) disable iff (reset)
      (advance && !a_in_range_ff) |=> (rsp_debounced_bits == '0 && rsp_toggled_bits == '0))
      else $error("out-of-range row returned nonzero bits");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_valid && rsp_out_row == $past(a_row_ff)))
      else $error("advanced row missing from result register");
`endif

endmodule

// ----- design/kmrd_row_store.sv -----
// ----------------------------------------------------------------------------
// kmrd_row_store
// Per-row storage of debounced bits and lockout counters. One registered
// read and one write per cycle, per-row valid bits for the zero reset value,
// and a bypass for a read that meets a write to the same row.
// ----------------------------------------------------------------------------
module kmrd_row_store #(
   parameter int ROWS  = kmrd_pkg::ROWS_DEFAULT,
   parameter int COLS  = kmrd_pkg::COLS_DEFAULT,
   parameter int ROW_W = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [ROW_W-1:0]             rd_addr,
   input  logic                         wr_en,
   input  logic [ROW_W-1:0]             wr_addr,
   input  logic [COLS-1:0]              wr_bits,
   input  logic [COLS*kmrd_pkg::CNT_W-1:0] wr_cnt,
   output logic [COLS-1:0]              rd_bits,
   output logic [COLS*kmrd_pkg::CNT_W-1:0] rd_cnt
);

   localparam int CW      = COLS * kmrd_pkg::CNT_W;
   localparam int ENTRY_W = COLS + CW;

   logic [ENTRY_W-1:0] mem [ROWS];
   logic [ENTRY_W-1:0] rd_ff;
   logic [ENTRY_W-1:0] byp_data_ff;
   logic [ENTRY_W-1:0] wr_entry;
   logic [ENTRY_W-1:0] rd_entry;
   logic [ROWS-1:0]    vld_ff;
   logic               rd_vld_ff;
   logic               byp_ff;
   logic               byp_in;

   assign wr_entry = {wr_bits, wr_cnt};
   assign byp_in   = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_ff       <= mem[rd_addr];
         byp_data_ff <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
         byp_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
            byp_ff    <= byp_in;
         end
      end
   end

   always_comb begin
      if (byp_ff) begin
         rd_entry = byp_data_ff;
      end else if (rd_vld_ff) begin
         rd_entry = rd_ff;
      end else begin
         rd_entry = '0;
      end
   end

   assign rd_bits = rd_entry[ENTRY_W-1:CW];
   assign rd_cnt  = rd_entry[CW-1:0];

`ifndef SYNTHESIS
   a_bypass_data: assert property (@(posedge clock) disable iff (reset)
      (rd_en && byp_in) |=> (rd_entry == $past(wr_entry)))
      else $error("same-row read did not see the concurrent write");

   a_unwritten_zero: assert property (@(posedge clock) disable iff (reset)
      (rd_en && !byp_in && !vld_ff[rd_addr]) |=> (rd_entry == '0))
      else $error("unwritten row did not read as zero");

   a_valid_set: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> vld_ff[$past(wr_addr)])
      else $error("row valid bit not set after write");
`endif

endmodule

// ----- design/kmrd_row_update.sv -----
// ----------------------------------------------------------------------------
// kmrd_row_update
// Per-key debounce step for one row: open keys take the raw value, locked
// keys hold and count down, changed keys reload their lockout counter.
// ----------------------------------------------------------------------------
module kmrd_row_update #(
   parameter int COLS = kmrd_pkg::COLS_DEFAULT
) (
   input  logic [COLS-1:0]                  raw_bits,
   input  logic [COLS-1:0]                  old_bits,
   input  logic [COLS*kmrd_pkg::CNT_W-1:0]  old_cnt,
   input  logic [kmrd_pkg::CNT_W-1:0]       lockout,
   output logic [COLS-1:0]                  new_bits,
   output logic [COLS-1:0]                  change,
   output logic [COLS*kmrd_pkg::CNT_W-1:0]  new_cnt
);

   localparam int CNT_W = kmrd_pkg::CNT_W;

   always_comb begin
      logic [CNT_W-1:0] cnt;
      logic             open;
      for (int c = 0; c < COLS; c++) begin
         cnt         = old_cnt[c*CNT_W +: CNT_W];
         open        = (cnt == '0);
         new_bits[c] = open ? raw_bits[c] : old_bits[c];
         change[c]   = new_bits[c] ^ old_bits[c];
         if (change[c]) begin
            new_cnt[c*CNT_W +: CNT_W] = lockout;
         end else if (open) begin
            new_cnt[c*CNT_W +: CNT_W] = '0;
         end else begin
            new_cnt[c*CNT_W +: CNT_W] = cnt - 1'b1;
         end
      end
   end

endmodule
